// ----- hw/rtl/tfms_pkg.sv -----
// Shared types and constants for the trigger firing-mode sequencer.
// Item, result and sequencer state structs, event and mode codes, timing constants.
// No dependencies.
`timescale 1ns / 1ps

package tfms_pkg;

  // Trigger event codes
  typedef enum logic [1:0] {
    CMD_IDLE    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_HOLD    = 2'd2,
    CMD_RELEASE = 2'd3
  } tfms_cmd_t;

  // Firing modes; the one unused code falls back to auto
  typedef enum logic [2:0] {
    MODE_AUTO    = 3'd0,
    MODE_BURST   = 3'd1,
    MODE_BINARY  = 3'd2,
    MODE_SAFE    = 3'd3,
    MODE_SEMI    = 3'd4,
    MODE_RAMP    = 3'd5,
    MODE_CHARGED = 3'd6
  } tfms_mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRE_MODE      = 2'd0;
  localparam logic [1:0] CFG_BURST_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_REVERSIBLE     = 2'd2;
  localparam logic [1:0] CFG_BINARY_TIMEOUT = 2'd3;

  // Rev request codes
  localparam logic [1:0] REV_KEEP  = 2'd0;
  localparam logic [1:0] REV_CLEAR = 2'd1;
  localparam logic [1:0] REV_SET   = 2'd2;

  // Flywheel speed codes
  localparam logic [1:0] RPM_KEEP   = 2'd0;
  localparam logic [1:0] RPM_NONE   = 2'd1;
  localparam logic [1:0] RPM_FULL   = 2'd2;
  localparam logic [1:0] RPM_CHARGE = 2'd3;

  // Buzzer pulse counts
  localparam logic [3:0] BUZZ_NONE     = 4'd0;
  localparam logic [3:0] BUZZ_SLOT     = 4'd4;
  localparam logic [3:0] BUZZ_OVERHEAT = 4'd10;

  // Shot counts
  localparam logic [9:0] SHOT_MAX   = 10'd1023;
  localparam logic [9:0] CONT_SHOTS = 10'd999;

  // Rate ramp, Q5.8
  localparam logic [31:0] RAMP_MS     = 32'd3000;
  localparam logic [12:0] RATE_MIN_Q  = 13'd768;
  localparam logic [12:0] RATE_MAX_Q  = 13'd5120;
  localparam logic [23:0] RAMP_ROUND  = 24'd1500;
  // ceil(2^36 / 3000): exact floor division for dividends below 2^24
  localparam logic [24:0] RAMP_RECIP  = 25'd22906493;
  localparam int          RAMP_SHIFT  = 36;

  // Charged shot timing (ms)
  localparam logic [31:0] READY_MS    = 32'd1646;
  localparam logic [31:0] SLOT2_MS    = 32'd2346;
  localparam logic [31:0] SLOT3_MS    = 32'd3046;
  localparam logic [31:0] OVERHEAT_MS = 32'd4046;
  localparam logic [31:0] LOCKOUT_MS  = 32'd2000;
  localparam logic [2:0]  PHASE_OVERHEAT = 3'd4;

  // Input item
  typedef struct packed {
    tfms_cmd_t   cmd;
    logic [31:0] time_now;
    logic [9:0]  shots_pending;
  } tfms_in_t;

  // Result item
  typedef struct packed {
    logic [9:0]  shots_out;
    logic [1:0]  rev_cmd;
    logic        rate_valid;
    logic [12:0] target_rate;
    logic [1:0]  rpm_cmd;
    logic [31:0] held_time;
    logic [3:0]  buzz_pulses;
    logic [31:0] trigger_time;
  } tfms_out_t;

  // Sequencer state carried between items
  typedef struct packed {
    logic [31:0] trigger_stamp;
    logic [31:0] charge_start;
    logic [31:0] lockout_until;
    logic [2:0]  last_phase;
    logic        hold_active;
  } tfms_state_t;

  // Configuration register set
  typedef struct packed {
    tfms_mode_t  fire_mode;
    logic [7:0]  burst_length;
    logic        reversible;
    logic [15:0] binary_timeout;
  } tfms_cfg_t;

endpackage

// ----- hw/rtl/tfms_step.sv -----
// Per-item decision logic of the trigger firing-mode sequencer.
// Maps one item, the configuration and the current state to a result and the next state.
// Depends on tfms_pkg.
`timescale 1ns / 1ps

module tfms_step
  import tfms_pkg::*;
(
  input  tfms_in_t    item,
  input  tfms_cfg_t   cfg,
  input  tfms_state_t state,
  output tfms_out_t   result,
  output tfms_state_t state_nxt
);

  // Add n shots when the queue is short, saturating at the maximum
  function automatic logic [9:0] accumulate(input logic [9:0] pend, input logic [7:0] n);
    logic [10:0] sum;
    sum = {1'b0, pend} + {3'b000, n};
    if ((pend < {2'b00, n}) || (pend == 10'd1)) begin
      return (sum > {1'b0, SHOT_MAX}) ? SHOT_MAX : sum[9:0];
    end
    return pend;
  endfunction

  logic [31:0] held_ramp;
  logic [11:0] ramp_t;
  logic [23:0] ramp_num;
  logic [48:0] ramp_prod;
  logic [12:0] ramp_q;
  logic [12:0] rate_ramp;
  logic [31:0] held_chg;
  logic        overheat;
  logic [2:0]  phase;
  logic [31:0] bin_limit;
  logic [7:0]  shot_n;
  logic [9:0]  shots;

  // Rate ramp: 768 + round(4352 * t / 3000), division by reciprocal multiply
  assign held_ramp = item.time_now - state.trigger_stamp;
  assign ramp_t    = held_ramp[11:0];
  assign ramp_num  = {ramp_t, 12'd0} + {4'd0, ramp_t, 8'd0} + RAMP_ROUND;
  assign ramp_prod = ramp_num * RAMP_RECIP;
  assign ramp_q    = ramp_prod[RAMP_SHIFT +: 13];
  assign rate_ramp = (held_ramp >= RAMP_MS) ? RATE_MAX_Q : (RATE_MIN_Q + ramp_q);

  // Charged shot: held time, overheat and armed slot phase
  assign held_chg = item.time_now - state.charge_start;
  assign overheat = (held_chg >= OVERHEAT_MS);
  always_comb begin
    priority if (overheat)          phase = PHASE_OVERHEAT;
    else if (held_chg >= SLOT3_MS)  phase = 3'd3;
    else if (held_chg >= SLOT2_MS)  phase = 3'd2;
    else if (held_chg >= READY_MS)  phase = 3'd1;
    else                            phase = 3'd0;
  end

  assign bin_limit = state.trigger_stamp + {16'd0, cfg.binary_timeout};
  assign shot_n    = (cfg.fire_mode == MODE_BURST) ? cfg.burst_length : 8'd1;

  // Mode rules
  always_comb begin
    state_nxt = state;
    shots     = item.shots_pending;
    result    = '0;
    result.target_rate = RATE_MIN_Q;

    unique case (cfg.fire_mode)
      MODE_BURST, MODE_SEMI: begin
        if (cfg.reversible) begin
          unique case (item.cmd)
            CMD_PRESS: begin
              state_nxt.trigger_stamp = item.time_now;
              result.rev_cmd = REV_SET;
            end
            CMD_HOLD:    result.rev_cmd = REV_SET;
            CMD_RELEASE: begin
              result.rev_cmd = REV_CLEAR;
              shots = accumulate(item.shots_pending, shot_n);
            end
            default: ;
          endcase
        end else if (item.cmd == CMD_PRESS) begin
          state_nxt.trigger_stamp = item.time_now;
          shots = accumulate(item.shots_pending, shot_n);
        end
      end
      MODE_BINARY: begin
        if ((item.cmd == CMD_PRESS) ||
            ((item.cmd == CMD_RELEASE) && (item.time_now < bin_limit))) begin
          state_nxt.trigger_stamp = item.time_now;
          shots = accumulate(item.shots_pending, cfg.burst_length);
        end
      end
      MODE_SAFE: shots = '0;
      MODE_RAMP: begin
        unique case (item.cmd)
          CMD_PRESS: begin
            state_nxt.trigger_stamp = item.time_now;
            result.rate_valid = 1'b1;
            shots = CONT_SHOTS;
          end
          CMD_HOLD: begin
            result.rate_valid  = 1'b1;
            result.target_rate = rate_ramp;
          end
          CMD_RELEASE: begin
            if (item.shots_pending > 10'd1) shots = 10'd1;
          end
          default: begin
            if (item.shots_pending == '0) result.rate_valid = 1'b1;
          end
        endcase
      end
      MODE_CHARGED: begin
        unique case (item.cmd)
          CMD_PRESS: begin
            if (item.time_now >= state.lockout_until) begin
              state_nxt.charge_start = item.time_now;
              state_nxt.hold_active  = 1'b1;
              state_nxt.last_phase   = '0;
              result.rev_cmd = REV_SET;
              result.rpm_cmd = RPM_CHARGE;
              shots = '0;
            end
          end
          CMD_HOLD: begin
            if (state.hold_active) begin
              if (phase > state.last_phase) begin
                result.buzz_pulses = overheat ? BUZZ_OVERHEAT : BUZZ_SLOT;
                state_nxt.last_phase = phase;
              end
              if (overheat) begin
                result.rev_cmd = REV_CLEAR;
                result.rpm_cmd = RPM_NONE;
                shots = '0;
              end else if (phase != 3'd0) begin
                result.rev_cmd = REV_SET;
                result.rpm_cmd = RPM_FULL;
              end else begin
                result.rev_cmd   = REV_SET;
                result.rpm_cmd   = RPM_CHARGE;
                result.held_time = held_chg;
              end
            end
          end
          CMD_RELEASE: begin
            if (state.hold_active) begin
              result.rev_cmd = REV_CLEAR;
              if (overheat) begin
                shots = '0;
                state_nxt.lockout_until = item.time_now + LOCKOUT_MS;
              end else begin
                shots = {7'd0, phase};
                state_nxt.hold_active = 1'b0;
                result.rpm_cmd = RPM_NONE;
              end
            end
          end
          default: begin
            if (state.hold_active && (item.time_now >= state.lockout_until)) begin
              state_nxt.hold_active = 1'b0;
              result.rpm_cmd = RPM_NONE;
            end
          end
        endcase
      end
      default: begin
        // auto, and the unused code
        if (item.cmd == CMD_PRESS) begin
          state_nxt.trigger_stamp = item.time_now;
          shots = {2'b00, cfg.burst_length};
        end else if ((item.cmd == CMD_RELEASE) && (item.shots_pending > 10'd1)) begin
          shots = 10'd1;
        end
      end
    endcase

    result.shots_out    = shots;
    result.trigger_time = state_nxt.trigger_stamp;
  end

endmodule

// ----- hw/rtl/trigger_firing_mode_sequencer_top.sv -----
// Top level of the trigger firing-mode sequencer.
// Input and result registers, configuration registers and sequencer state.
// Depends on tfms_pkg and tfms_step.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one trigger event
//   with its millisecond timestamp and the pending shot count. The result
//   channel (out_valid / out_stall / out_data) returns exactly one result
//   item per input item, in order.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   mode, burst length, reversible flag and binary timeout; cfg_ready is
//   always high. Write it only while no item is in flight.
//   Path: an accepted item lands in the input register, and its result is
//   registered in the result register once that register is free, and then
//   shows on out_data. Throughput is one item per cycle while out_stall does
//   not hold a result, set by the single decision stage between the input
//   and result registers; the state it updates is registered at the same
//   edge as the result, ready for the following item.
//   Reset: both stages empty, state cleared, registers at their defaults
//   (auto mode, burst length 3, not reversible, binary timeout 500 ms).
//   While out_stall holds a result, the input register keeps one more item
//   and then in_stall rises until the result is taken.

module trigger_firing_mode_sequencer_top
  import tfms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tfms_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tfms_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tfms_cfg_t   cfg_r;
  tfms_state_t state_r;
  tfms_state_t state_nxt;
  tfms_in_t    in_r;
  logic        in_vld_r;
  tfms_out_t   out_r;
  tfms_out_t   result;
  logic        out_vld_r;
  logic        adv;
  logic        in_take;

  // Handshake: the decision stage moves whenever the result register is free
  assign adv       = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fire_mode      <= MODE_AUTO;
      cfg_r.burst_length   <= 8'd3;
      cfg_r.reversible     <= 1'b0;
      cfg_r.binary_timeout <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRE_MODE:      cfg_r.fire_mode      <= tfms_mode_t'(cfg_data[2:0]);
        CFG_BURST_LENGTH:   cfg_r.burst_length   <= cfg_data[7:0];
        CFG_REVERSIBLE:     cfg_r.reversible     <= cfg_data[0];
        CFG_BINARY_TIMEOUT: cfg_r.binary_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  // Decision logic
  tfms_step u_step (
    .item      (in_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .result    (result),
    .state_nxt (state_nxt)
  );

  // Sequencer state advances with each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= result;
    end
  end

  // Checks
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("sequencer state changed without an item");

  a_hold_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r.hold_active) |-> $past(adv) && ($past(cfg_r.fire_mode) == MODE_CHARGED))
    else $error("charge hold ended outside charged mode");

  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.target_rate >= RATE_MIN_Q) && (out_r.target_rate <= RATE_MAX_Q))
    else $error("target rate out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && out_stall |=> $stable(in_r) && in_vld_r)
    else $error("held item lost under stall");

endmodule
